// ===== design/tacp_pkg.sv =====
// ----------------------------------------------------------------------------
// tacp_pkg
// Shared types and constants for the time/alarm command parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tacp_pkg;

    // Default payload capacity of one packet, in bytes
    localparam int PACKET_DEPTH_DEFAULT = 128;

    // Operation codes carried with each request
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Command characters
    localparam logic [7:0] CHAR_TIME    = 8'h45;  // 'E'
    localparam logic [7:0] CHAR_ALARM   = 8'h4C;  // 'L'
    localparam logic [7:0] CHAR_SET     = 8'h3D;  // '='
    localparam logic [7:0] CHAR_QUERY   = 8'h3F;  // '?'
    localparam logic [7:0] CHAR_END     = 8'h2E;  // '.'

    // Command flag values
    localparam logic [1:0] FLAG_NONE        = 2'd0;
    localparam logic [1:0] FLAG_TIME_SET    = 2'd1;
    localparam logic [1:0] FLAG_ALARM       = 2'd2;
    localparam logic [1:0] FLAG_TIME_QUERY  = 2'd3;

    // One request: an operation and a received byte
    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } cmd_t;

    // One result
    typedef struct packed {
        logic [1:0] command_flag;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [6:0] payload_index;
        logic       packet_done;
        logic [7:0] packet_length;
        logic       overflow;
    } res_t;

endpackage

`default_nettype wire

// ===== design/time_alarm_command_parser.sv =====
// ----------------------------------------------------------------------------
// time_alarm_command_parser
// Parses time/alarm set and query commands from a received byte stream.
// ----------------------------------------------------------------------------
// Takes one request per cycle and returns exactly one result per request:
// the request is captured in an input register, decoded by a single parse
// step (state, byte counter, command flag) and written to a result register.
// Throughput is one request per clock while res_stall is low; a stalled
// result holds and back-pressure reaches cmd_stall in the same cycle. The
// command flag stays set until a clear request, and new commands are ignored
// while it is set.
`default_nettype none

module time_alarm_command_parser
    import tacp_pkg::*;
#(
    parameter int PACKET_DEPTH = PACKET_DEPTH_DEFAULT
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_stall,
    input  wire cmd_t cmd,
    output logic      res_valid,
    input  wire logic res_stall,
    output res_t      res
);

    logic stage_valid_reg;
    cmd_t stage_reg;
    logic res_valid_reg;
    res_t res_reg;
    res_t parse_res;
    logic advance;

    // Result register moves when empty or taken
    assign advance   = !res_valid_reg || !res_stall;
    assign cmd_stall = stage_valid_reg && !advance;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Hold the accepted request in the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (!cmd_stall)
        begin
            stage_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!cmd_stall && cmd_valid)
        begin
            stage_reg <= cmd;
        end
    end

    tacp_parser #(
        .PACKET_DEPTH(PACKET_DEPTH)
    ) u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (stage_valid_reg && advance),
        .cmd   (stage_reg),
        .res   (parse_res)
    );

    // Load the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage_valid_reg)
        begin
            res_reg <= parse_res;
        end
    end

endmodule

`default_nettype wire

// ===== design/tacp_parser.sv =====
// ----------------------------------------------------------------------------
// tacp_parser
// Parse state, payload byte counter and command flag. Consumes one request
// per cycle when fire is high and produces its result combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module tacp_parser
    import tacp_pkg::*;
#(
    parameter int PACKET_DEPTH = PACKET_DEPTH_DEFAULT
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic fire,
    input  wire cmd_t cmd,
    output res_t      res
);

    localparam int CW = $clog2(PACKET_DEPTH + 1);

    localparam logic [2:0] ST_IDLE        = 3'd0;
    localparam logic [2:0] ST_TIME_CMD    = 3'd1;
    localparam logic [2:0] ST_ALARM_CMD   = 3'd2;
    localparam logic [2:0] ST_TIME_DATA   = 3'd3;
    localparam logic [2:0] ST_ALARM_DATA  = 3'd4;
    localparam logic [2:0] ST_TIME_TAIL   = 3'd5;
    localparam logic [2:0] ST_ALARM_TAIL  = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    flag_reg, flag_next;
    logic [7:0]    count_lo;
    logic          has_room;
    logic [7:0]    b;

    assign b        = cmd.rx_byte;
    assign count_lo = 8'(count_reg);
    assign has_room = (count_reg < CW'(PACKET_DEPTH));

    // Decode one request against the current parse state
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        flag_next  = flag_reg;
        res        = '0;

        if (cmd.op == OP_CLEAR)
        begin
            flag_next = FLAG_NONE;
        end
        else
        begin
            unique case (state_reg) inside
                ST_IDLE:
                begin
                    if (flag_reg == FLAG_NONE && b == CHAR_TIME)
                    begin
                        state_next = ST_TIME_CMD;
                        count_next = '0;
                    end
                    else if (flag_reg == FLAG_NONE && b == CHAR_ALARM)
                    begin
                        state_next = ST_ALARM_CMD;
                        count_next = '0;
                    end
                end
                ST_TIME_CMD, ST_ALARM_CMD:
                begin
                    if (b == CHAR_SET)
                    begin
                        state_next = (state_reg == ST_TIME_CMD) ? ST_TIME_DATA
                                                                : ST_ALARM_DATA;
                    end
                    else if (b == CHAR_QUERY)
                    begin
                        state_next = ST_IDLE;
                        flag_next  = (state_reg == ST_TIME_CMD) ? FLAG_TIME_QUERY
                                                                : FLAG_ALARM;
                    end
                end
                ST_TIME_DATA, ST_ALARM_DATA:
                begin
                    if (b == CHAR_END)
                    begin
                        state_next = (state_reg == ST_TIME_DATA) ? ST_TIME_TAIL
                                                                 : ST_ALARM_TAIL;
                    end
                    else if (has_room)
                    begin
                        res.payload_valid = 1'b1;
                        res.payload_byte  = b;
                        res.payload_index = count_lo[6:0];
                        count_next        = count_reg + CW'(1);
                    end
                    else
                    begin
                        res.overflow = 1'b1;
                    end
                end
                ST_TIME_TAIL, ST_ALARM_TAIL:
                begin
                    state_next        = ST_IDLE;
                    flag_next         = (state_reg == ST_TIME_TAIL) ? FLAG_TIME_SET
                                                                    : FLAG_ALARM;
                    res.packet_done   = 1'b1;
                    res.packet_length = count_lo;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end

        res.command_flag = flag_next;
    end

    // Advance parser state on each consumed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            flag_reg  <= FLAG_NONE;
        end
        else if (fire)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            flag_reg  <= flag_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/tacp_checker.sv =====
// ----------------------------------------------------------------------------
// tacp_checker
// Port-level checks for the time/alarm command parser.
// ----------------------------------------------------------------------------
`default_nettype none

module tacp_checker
    import tacp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    input  wire logic cmd_stall,
    input  wire cmd_t cmd,
    input  wire logic res_valid,
    input  wire logic res_stall,
    input  wire res_t res
);

    // Stalled request keeps its valid and payload
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
        else $error("request changed while stalled");

    // Stalled result keeps its valid
    a_res_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result valid dropped while stalled");

    // Stalled result keeps its payload
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(res))
        else $error("result payload changed while stalled");

    // A completed packet leaves a set flag
    a_done_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.packet_done |->
            (res.command_flag == FLAG_TIME_SET || res.command_flag == FLAG_ALARM))
        else $error("packet done without set flag");

    // Stored, dropped and completed bytes are mutually exclusive
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $onehot0({res.payload_valid, res.overflow, res.packet_done}))
        else $error("conflicting result indications");

endmodule

bind time_alarm_command_parser tacp_checker u_tacp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

`default_nettype wire
